### rtl/core/jse_pkg.sv
// Shared types, character codes and helper functions for the JSON string escaper.
package jse_pkg;

    localparam int JSE_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_HEX_AF = 8'h57;  // 'a' - 10

    // Emission kinds: plain byte, two-byte escape, six-byte \u00XX escape
    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_ESC   = 2'd1,
        KIND_UNI   = 2'd2
    } kind_t;

    typedef logic [2:0] pos_t;

    // One classified input item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] code;   // raw byte (plain, unicode) or second escape char
        logic       trunc;
    } desc_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        hex_digit = (nib < 4'd10) ? (CH_ZERO + {4'd0, nib}) : (CH_HEX_AF + {4'd0, nib});
    endfunction

    function automatic pos_t last_pos(input kind_t kind);
        case (kind)
            KIND_PLAIN: last_pos = 3'd0;
            KIND_ESC:   last_pos = 3'd1;
            KIND_UNI:   last_pos = 3'd5;
            default:    last_pos = 3'd0;
        endcase
    endfunction

endpackage

### rtl/core/jse_front.sv
// Front end: accepts raw bytes, tracks UTF-8 sequences and classifies each byte.
module jse_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_stall,
    input  logic [7:0]    data_byte,
    input  logic          end_of_string,
    input  logic          queue_full,
    output logic          push,
    output jse_pkg::desc_t push_desc
);
    import jse_pkg::*;

    logic [1:0] cont_reg;
    logic [1:0] cont_next;
    logic [1:0] owed;
    logic [1:0] lead_extra;
    logic       fire;

    assign byte_stall = queue_full;
    assign fire       = byte_valid && !queue_full;
    assign push       = fire;

    always_comb
    begin
        if ((data_byte & 8'hE0) == 8'hC0)
            lead_extra = 2'd1;
        else if ((data_byte & 8'hF0) == 8'hE0)
            lead_extra = 2'd2;
        else if ((data_byte & 8'hF8) == 8'hF0)
            lead_extra = 2'd3;
        else
            lead_extra = 2'd0;
    end

    always_comb
    begin
        push_desc.kind = KIND_PLAIN;
        push_desc.code = data_byte;
        if (cont_reg != 2'd0) begin
            owed = cont_reg - 2'd1;
        end
        else begin
            owed = lead_extra;
            if (lead_extra == 2'd0) begin
                if (data_byte == CH_QUOTE || data_byte == CH_BSLASH) begin
                    push_desc.kind = KIND_ESC;
                end
                else if (data_byte == CH_BS) begin
                    push_desc.kind = KIND_ESC;
                    push_desc.code = CH_LOW_B;
                end
                else if (data_byte == CH_FF) begin
                    push_desc.kind = KIND_ESC;
                    push_desc.code = CH_LOW_F;
                end
                else if (data_byte == CH_LF) begin
                    push_desc.kind = KIND_ESC;
                    push_desc.code = CH_LOW_N;
                end
                else if (data_byte == CH_CR) begin
                    push_desc.kind = KIND_ESC;
                    push_desc.code = CH_LOW_R;
                end
                else if (data_byte == CH_TAB) begin
                    push_desc.kind = KIND_ESC;
                    push_desc.code = CH_LOW_T;
                end
                else if (data_byte < CH_SPACE || data_byte == CH_DEL) begin
                    push_desc.kind = KIND_UNI;
                end
            end
        end
        push_desc.trunc = end_of_string && (owed != 2'd0);
        cont_next = end_of_string ? 2'd0 : owed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cont_reg <= 2'd0;
        else if (fire)
            cont_reg <= cont_next;
    end

`ifndef ASSERT_OFF
    // A string never leaves a sequence open behind it
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && end_of_string |=> cont_reg == 2'd0)
        else $error("continuation count not cleared at end of string");
`endif

endmodule

### rtl/core/jse_fifo.sv
// Short show-ahead queue of classified items between front and back end.
module jse_fifo #(
    parameter int DEPTH = jse_pkg::JSE_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  jse_pkg::desc_t push_desc,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output jse_pkg::desc_t head
);
    import jse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
`endif

endmodule

### rtl/core/jse_back.sv
// Back end: expands each classified item into output bytes, one per cycle while the output is not stalled.
module jse_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  jse_pkg::desc_t head,
    output logic           pop,
    output logic           text_valid,
    input  logic           text_stall,
    output logic [7:0]     out_byte,
    output logic           run_last,
    output logic           truncated_utf8
);
    import jse_pkg::*;

    pos_t       pos_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       trunc_reg;
    logic       load;
    logic       at_end;
    logic [7:0] byte_next;

    assign load   = !empty && (!valid_reg || !text_stall);
    assign at_end = (pos_reg == last_pos(head.kind));
    assign pop    = load && at_end;

    always_comb
    begin
        byte_next = head.code;
        case (head.kind)
            KIND_PLAIN: byte_next = head.code;
            KIND_ESC:   byte_next = (pos_reg == 3'd0) ? CH_BSLASH : head.code;
            KIND_UNI:
            begin
                case (pos_reg)
                    3'd0:    byte_next = CH_BSLASH;
                    3'd1:    byte_next = CH_LOW_U;
                    3'd2:    byte_next = CH_ZERO;
                    3'd3:    byte_next = CH_ZERO;
                    3'd4:    byte_next = hex_digit(head.code[7:4]);
                    default: byte_next = hex_digit(head.code[3:0]);
                endcase
            end
            default:    byte_next = head.code;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else begin
            if (load) begin
                valid_reg <= 1'b1;
                pos_reg   <= at_end ? 3'd0 : pos_reg + 3'd1;
            end
            else if (!text_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg  <= byte_next;
            last_reg  <= at_end;
            trunc_reg <= at_end && head.trunc;
        end
    end

    assign text_valid     = valid_reg;
    assign out_byte       = byte_reg;
    assign run_last       = last_reg;
    assign truncated_utf8 = trunc_reg;

`ifndef ASSERT_OFF
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pos_reg <= last_pos(head.kind))
        else $error("expansion position past end of item");
    a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && trunc_reg |-> last_reg)
        else $error("truncation flag on non-final byte");
`endif

endmodule

### rtl/core/json_string_escaper.sv
// Top level of the JSON string escaper: front end, item queue and back end.
//
//  channel   valid        stall        payload                               dir
//  -------   ----------   ----------   -----------------------------------   ---
//  input     byte_valid   byte_stall   data_byte, end_of_string              in
//  output    text_valid   text_stall   out_byte, run_last, truncated_utf8    out
//
//  One input byte is taken per cycle while the queue has room; an escape
//  expands to 2 or 6 output bytes, emitted one per cycle by the back end
//  while the output is not stalled.
//  Reset clears the UTF-8 continuation count, queue pointers and output valid.
//  Output stall freezes the output register; the queue keeps absorbing input
//  until it fills, then byte_stall rises.
module json_string_escaper #(
    parameter int QUEUE_DEPTH = jse_pkg::JSE_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_string,
    output logic       text_valid,
    input  logic       text_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       truncated_utf8
);
    import jse_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    desc_t push_desc;
    desc_t head;

    // Classification and UTF-8 sequence tracking
    jse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .queue_full    (full),
        .push          (push),
        .push_desc     (push_desc)
    );

    // Decouples input acceptance from multi-cycle expansion
    jse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    // Byte-per-cycle expansion, while the output is not stalled, into a registered output
    jse_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (empty),
        .head           (head),
        .pop            (pop),
        .text_valid     (text_valid),
        .text_stall     (text_stall),
        .out_byte       (out_byte),
        .run_last       (run_last),
        .truncated_utf8 (truncated_utf8)
    );

endmodule

### tb/json_string_escaper_tb.sv
// Self-checking testbench for json_string_escaper: random strings, bursty input, output stalls.
module json_string_escaper_tb;

    import jse_pkg::*;

    // Generous bound: ~300 bytes, each up to 6 output bytes under heavy stall.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 250;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // Bytes the escaper treats specially outside a UTF-8 sequence (slash is a control case)
    localparam logic [7:0] SPECIAL_BYTES [8] = '{
        CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB, CH_SLASH
    };

    // One byte of an input string waiting to be sent
    typedef struct {
        logic [7:0] data;
        logic       eos;
        logic       drain;  // hold this byte back until all output has come out
    } string_byte_t;

    // One byte of escaped output text
    typedef struct {
        logic [7:0] text;
        logic       last;
        logic       trunc;
    } text_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] data_byte = 8'h00;
    logic       end_of_string = 1'b0;
    logic       text_valid;
    logic       text_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       truncated_utf8;

    string_byte_t pending_bytes [$];
    text_byte_t   expected_text [$];

    logic [1:0] utf8_owed = 2'd0;  // predictor copy of the continuation count
    int         mismatches = 0;
    int         cycle_count = 0;

    // Sender pacing
    int burst_left = 0;
    int gap_left = 0;
    bit sender_quiet = 1'b0;

    // Receiver pacing
    int rx_left = 0;
    int rx_mode = 0;

    json_string_escaper dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .data_byte      (data_byte),
        .end_of_string  (end_of_string),
        .text_valid     (text_valid),
        .text_stall     (text_stall),
        .out_byte       (out_byte),
        .run_last       (run_last),
        .truncated_utf8 (truncated_utf8)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] utf8_lead(input int extra);
        case (extra)
            1:       utf8_lead = {3'b110, 5'($urandom)};
            2:       utf8_lead = {4'b1110, 4'($urandom)};
            default: utf8_lead = {5'b11110, 3'($urandom)};
        endcase
    endfunction

    // Mostly proper 10xxxxxx bytes; now and then any byte, which must still pass verbatim
    function automatic logic [7:0] utf8_tail();
        if ($urandom_range(0, 7) == 0)
        begin
            utf8_tail = 8'($urandom);
        end
        else
        begin
            utf8_tail = {2'b10, 6'($urandom)};
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (CH_ZERO + 8'(nib)) : (CH_LOWER_A + 8'(nib) - 8'd10);
    endfunction

    // Escape one transferred byte and queue the output text it must produce.
    task automatic predict_escape(input logic [7:0] b, input logic eos);
        logic [7:0] text [6];
        int         n;
        logic [1:0] owed;
        logic       trunc_now;
        text_byte_t r;
        n = 0;
        owed = 2'd0;
        if (utf8_owed != 2'd0)
        begin
            // inside a sequence: verbatim, no inspection
            text[0] = b;
            n = 1;
            owed = utf8_owed - 2'd1;
        end
        else
        begin
            casez (b)
                8'b110?????: owed = 2'd1;
                8'b1110????: owed = 2'd2;
                8'b11110???: owed = 2'd3;
                default:     owed = 2'd0;
            endcase
            if (owed != 2'd0)
            begin
                text[0] = b;
                n = 1;
            end
            else
            begin
                text[0] = CH_BSLASH;
                n = 2;
                case (b)
                    CH_QUOTE, CH_BSLASH: text[1] = b;
                    CH_BS:  text[1] = CH_LOW_B;
                    CH_FF:  text[1] = CH_LOW_F;
                    CH_LF:  text[1] = CH_LOW_N;
                    CH_CR:  text[1] = CH_LOW_R;
                    CH_TAB: text[1] = CH_LOW_T;
                    default:
                    begin
                        if (b < CH_SPACE || b == CH_DEL)
                        begin
                            text[1] = CH_LOW_U;
                            text[2] = CH_ZERO;
                            text[3] = CH_ZERO;
                            text[4] = hex_char(b[7:4]);
                            text[5] = hex_char(b[3:0]);
                            n = 6;
                        end
                        else
                        begin
                            text[0] = b;
                            n = 1;
                        end
                    end
                endcase
            end
        end
        trunc_now = eos && (owed != 2'd0);
        utf8_owed = eos ? 2'd0 : owed;
        for (int k = 0; k < n; k++)
        begin
            r.text  = text[k];
            r.last  = (k == n - 1);
            r.trunc = r.last && trunc_now;
            expected_text.push_back(r);
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic eos, input logic drain);
        string_byte_t item;
        item.data  = b;
        item.eos   = eos;
        item.drain = drain;
        pending_bytes.push_back(item);
    endtask

    // Driver: a byte transfers when byte_valid is high and byte_stall low at the edge.
    // While stalled, valid and payload are held; otherwise the next byte goes out
    // unless the sender is in a gap or waiting for the output to drain.
    always @(posedge clk)
    begin
        logic accepted;
        accepted = byte_valid && (byte_stall === 1'b0);
        if (rst_n)
        begin
            if (accepted)
            begin
                predict_escape(pending_bytes[0].data, pending_bytes[0].eos);
                void'(pending_bytes.pop_front());
            end
            if (!(byte_valid && !accepted))
            begin
                if ($urandom_range(0, 31) == 0)
                begin
                    sender_quiet = !sender_quiet;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    byte_valid <= 1'b0;
                end
                else if (pending_bytes.size() == 0
                         || (pending_bytes[0].drain && expected_text.size() != 0))
                begin
                    byte_valid <= 1'b0;
                end
                else
                begin
                    byte_valid    <= 1'b1;
                    data_byte     <= pending_bytes[0].data;
                    end_of_string <= pending_bytes[0].eos;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // burst over: start a new one, after a gap unless sender_quiet is set
                        burst_left = $urandom_range(0, 24);
                        gap_left = sender_quiet ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver stall pattern: free-running, random, or mostly stalled, in stretches.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(8, 40);
        end
        else
        begin
            rx_left--;
        end
        case (rx_mode)
            0:       text_stall <= 1'b0;
            1:       text_stall <= ($urandom_range(0, 2) == 0);
            default: text_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Monitor: every output transfer is checked against the oldest expected byte.
    always @(posedge clk)
    begin
        text_byte_t want;
        if (rst_n && text_valid === 1'b1 && text_stall == 1'b0)
        begin
            if (expected_text.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("unexpected output: out_byte=%h run_last=%b truncated_utf8=%b",
                             out_byte, run_last, truncated_utf8);
                end
            end
            else
            begin
                want = expected_text.pop_front();
                if (out_byte !== want.text || run_last !== want.last
                    || truncated_utf8 !== want.trunc)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want.text, want.last, want.trunc,
                                 out_byte, run_last, truncated_utf8);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("json_string_escaper_tb: errors");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] str [$];
        int         random_count;
        int         pieces;
        int         extra;
        bit         drain;
        random_count = 0;

        // Directed: field extremes, every escape, slash, invalid leads.
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h1F, 1'b0, 1'b0);
        add_byte(CH_DEL, 1'b0, 1'b0);
        add_byte(CH_QUOTE, 1'b0, 1'b0);
        add_byte(CH_BSLASH, 1'b0, 1'b0);
        add_byte(CH_BS, 1'b0, 1'b0);
        add_byte(CH_FF, 1'b0, 1'b0);
        add_byte(CH_LF, 1'b0, 1'b0);
        add_byte(CH_CR, 1'b0, 1'b0);
        add_byte(CH_TAB, 1'b0, 1'b0);
        add_byte(CH_SLASH, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);    // stray continuation
        add_byte(8'hF8, 1'b0, 1'b0);    // invalid lead
        add_byte(8'hFF, 1'b1, 1'b0);
        // two-byte sequence whose tail is a quote: must pass unescaped
        add_byte(8'hC3, 1'b0, 1'b0);
        add_byte(CH_QUOTE, 1'b0, 1'b0);
        // three and four byte sequences, last one completing at end of string
        add_byte(8'hE2, 1'b0, 1'b0);
        add_byte(8'h82, 1'b0, 1'b0);
        add_byte(8'hAC, 1'b0, 1'b0);
        add_byte(8'hF0, 1'b0, 1'b0);
        add_byte(8'h9F, 1'b0, 1'b0);
        add_byte(8'h98, 1'b0, 1'b0);
        add_byte(8'h80, 1'b1, 1'b0);
        // truncated sequences: mid-sequence end, and a lead that ends the string
        add_byte(8'hE2, 1'b0, 1'b1);
        add_byte(8'h82, 1'b1, 1'b0);
        add_byte(8'hF0, 1'b1, 1'b0);
        add_byte(8'hC0, 1'b1, 1'b0);

        // Random strings built from text, controls, escapes, noise and UTF-8 runs.
        while (random_count < RANDOM_ITEMS)
        begin
            str.delete();
            pieces = $urandom_range(1, 6);
            drain = ($urandom_range(0, 24) == 0);
            for (int p = 0; p < pieces; p++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: str.push_back(8'($urandom_range(32'h20, 32'h7E)));
                    3:
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            str.push_back(CH_DEL);
                        end
                        else
                        begin
                            str.push_back(8'($urandom_range(0, 32'h1F)));
                        end
                    end
                    4: str.push_back(SPECIAL_BYTES[$urandom_range(0, 7)]);
                    5: str.push_back(8'($urandom));
                    default:
                    begin
                        extra = $urandom_range(1, 3);
                        str.push_back(utf8_lead(extra));
                        for (int k = 0; k < extra; k++)
                        begin
                            str.push_back(utf8_tail());
                        end
                    end
                endcase
            end
            // now and then end the string inside a sequence
            if ($urandom_range(0, 5) == 0)
            begin
                extra = $urandom_range(1, 3);
                str.push_back(utf8_lead(extra));
                for (int k = $urandom_range(0, extra - 1); k > 0; k--)
                begin
                    str.push_back(utf8_tail());
                end
            end
            foreach (str[i])
            begin
                add_byte(str[i], i == str.size() - 1, drain && i == 0);
            end
            random_count += str.size();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        // let any stray extra output show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("json_string_escaper_tb: clean");
        end
        else
        begin
            $display("json_string_escaper_tb: errors");
        end
        $finish;
    end

endmodule
